>>> rtl/csp_pkg.sv
// shared types, codes and defaults for the checked byte scratchpad
package csp_pkg;

    // default memory size in bytes
    localparam int unsigned SIZE_BYTES_DEF = 65536;

    // request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // access size codes
    localparam logic [1:0] SIZE_B1 = 2'd0;
    localparam logic [1:0] SIZE_B2 = 2'd1;
    localparam logic [1:0] SIZE_B4 = 2'd2;
    localparam logic [1:0] SIZE_B8 = 2'd3;

    // one request as held inside the block
    typedef struct packed {
        logic        is_write;
        logic [1:0]  size;
        logic        sext;
        logic [31:0] addr;
        logic [63:0] wdata;
    } req_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_ACCESS
    } state_t;

endpackage

>>> rtl/csp_ram.sv
// generic single-port synchronous ram with registered read
module csp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic [AW-1:0]    addr,
    input  logic             re,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/csp_check.sv
// alignment and range check of one request
module csp_check #(
    parameter int unsigned SIZE_BYTES = csp_pkg::SIZE_BYTES_DEF
) (
    input  csp_pkg::req_t req,
    output logic          fault
);
    import csp_pkg::*;

    logic [2:0]  align_mask;
    logic [3:0]  nbytes;
    logic [32:0] end_addr;
    logic        misaligned;
    logic        past_end;

    // low address bits that must be zero, and the byte count
    always_comb begin
        case (req.size)
            SIZE_B1: begin
                align_mask = 3'b000;
                nbytes     = 4'd1;
            end
            SIZE_B2: begin
                align_mask = 3'b001;
                nbytes     = 4'd2;
            end
            SIZE_B4: begin
                align_mask = 3'b011;
                nbytes     = 4'd4;
            end
            SIZE_B8: begin
                align_mask = 3'b111;
                nbytes     = 4'd8;
            end
            default: begin
                align_mask = 3'b111;
                nbytes     = 4'd8;
            end
        endcase
    end

    // end of the access must stay inside the memory
    assign end_addr   = {1'b0, req.addr} + {29'd0, nbytes};
    assign misaligned = (req.addr[2:0] & align_mask) != 3'b000;
    assign past_end   = end_addr > 33'(SIZE_BYTES);
    assign fault      = misaligned | past_end;

endmodule

>>> rtl/csp_lane.sv
// byte lane merge for writes and extract with extension for reads
module csp_lane (
    input  csp_pkg::req_t req,
    input  logic [63:0]   word,
    output logic [63:0]   merged,
    output logic [63:0]   value
);
    import csp_pkg::*;

    logic [63:0] mask;
    logic [5:0]  shift;
    logic [63:0] raw;

    // mask of the bytes touched, at the low end
    always_comb begin
        case (req.size)
            SIZE_B1: mask = 64'h0000_0000_0000_00ff;
            SIZE_B2: mask = 64'h0000_0000_0000_ffff;
            SIZE_B4: mask = 64'h0000_0000_ffff_ffff;
            SIZE_B8: mask = 64'hffff_ffff_ffff_ffff;
            default: mask = 64'hffff_ffff_ffff_ffff;
        endcase
    end

    assign shift  = {req.addr[2:0], 3'b000};
    assign merged = (word & ~(mask << shift)) | ((req.wdata & mask) << shift);
    assign raw    = (word >> shift) & mask;

    // sign extension only for two and four byte reads
    always_comb begin
        value = raw;
        if (req.sext) begin
            case (req.size)
                SIZE_B2: value = {{48{raw[15]}}, raw[15:0]};
                SIZE_B4: value = {{32{raw[31]}}, raw[31:0]};
                default: value = raw;
            endcase
        end
    end

endmodule

>>> rtl/checked_byte_scratchpad.sv
// top level of the checked byte scratchpad: sequencer, request and result registers
//
//  channel | dir | handshake          | tdata / tuser
//  s_      | in  | s_tvalid, s_tready | size, sign_extend, address, write_data / req_type
//  m_      | out | m_tvalid, m_tready | read_data / fault
//
// each item is handled as an accept step with the word read issued, then an access step in which the
// ram read data is merged and written back or extracted into the result register.
// the single ram port carries the read and then the write back of one item.
// reset clears the sequencer and the result valid; memory contents stay undefined.
// a stalled result holds the block in the access state until it is taken.
module checked_byte_scratchpad #(
    parameter int unsigned SIZE_BYTES = csp_pkg::SIZE_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // size[1:0], sign_extend[2], address[34:3], write_data[98:35], zero fill
    input  logic [103:0] s_tdata,
    // req_type[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[63:0]
    output logic [63:0]  m_tdata,
    // fault[0]
    output logic [0:0]   m_tuser
);
    import csp_pkg::*;

    localparam int unsigned WORD_COUNT = (SIZE_BYTES + 7) / 8;
    localparam int unsigned WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    state_t             state_reg, state_next;
    req_t               in_req;
    req_t               req_reg;
    logic               fault_reg;
    logic               in_fault;
    logic               accept;
    logic               push;
    logic               ram_re;
    logic               ram_we;
    logic [WORD_AW-1:0] ram_addr;
    logic [63:0]        ram_rdata;
    logic [63:0]        merged;
    logic [63:0]        rd_value;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_fault_reg;

    // unpack the incoming item
    assign in_req.is_write = s_tuser[0];
    assign in_req.size     = s_tdata[1:0];
    assign in_req.sext     = s_tdata[2];
    assign in_req.addr     = s_tdata[34:3];
    assign in_req.wdata    = s_tdata[98:35];

    csp_check #(
        .SIZE_BYTES(SIZE_BYTES)
    ) u_check (
        .req  (in_req),
        .fault(in_fault)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ACCESS: begin
                push = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign ram_re = accept && !in_fault;
    assign ram_we = push && !fault_reg && (req_reg.is_write == REQ_WRITE);

    // ram address comes from the incoming item in the idle state, else from the held one
    assign ram_addr = (state_reg == ST_IDLE) ? in_req.addr[WORD_AW+2:3]
                                             : req_reg.addr[WORD_AW+2:3];

    csp_ram #(
        .WIDTH(64),
        .DEPTH(WORD_COUNT),
        .AW   (WORD_AW)
    ) u_ram (
        .aclk (aclk),
        .addr (ram_addr),
        .re   (ram_re),
        .we   (ram_we),
        .wdata(merged),
        .rdata(ram_rdata)
    );

    csp_lane u_lane (
        .req   (req_reg),
        .word  (ram_rdata),
        .merged(merged),
        .value (rd_value)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= in_req;
            fault_reg <= in_fault;
        end
        if (push) begin
            out_fault_reg <= fault_reg;
            out_data_reg  <= (fault_reg || (req_reg.is_write == REQ_WRITE)) ? 64'd0
                                                                             : rd_value;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_fault_reg;

`ifndef NO_ASSERTIONS
    // memory is written only for a good write in the access step
    a_write_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_ACCESS) && !fault_reg && req_reg.is_write)
        else $error("ram written outside a good write access");

    // an accepted item moves to the access step
    a_accept_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_ACCESS)
        else $error("accepted item did not enter the access step");

    // a faulting result carries zero data
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
        else $error("fault result with nonzero data");

    // a result appears only after an access step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_ACCESS))
        else $error("result without an access step");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the checked byte scratchpad with a byte-level shadow memory
module tb_top;
    import csp_pkg::*;

    localparam int unsigned MEM_BYTES   = SIZE_BYTES_DEF;
    localparam int          MAX_REPORTS = 10;

    // one response as returned on the m_ channel
    typedef struct packed {
        logic [63:0] rdata;
        logic        fault;
    } resp_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // size[1:0], sign_extend[2], address[34:3], write_data[98:35], zero fill
    logic [103:0] s_tdata  = '0;
    // req_type[0]
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // read_data[63:0]
    logic [63:0]  m_tdata;
    // fault[0]
    logic [0:0]   m_tuser;

    // shadow copy of the scratchpad, one byte per entry, with a written flag
    logic [7:0]   shadow_mem [MEM_BYTES];
    bit           byte_valid [MEM_BYTES];
    resp_t        pending_resp [$];
    int           error_count = 0;
    bit           no_idle     = 1'b0;

    checked_byte_scratchpad dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #10 aclk = ~aclk;

    // run limit
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // expected response of one access, updating the shadow memory on writes
    function automatic resp_t predict_access(input req_t rq);
        int unsigned nbytes;
        logic [63:0] end_addr;
        resp_t       r;
        int          i;
        nbytes   = 1 << rq.size;
        end_addr = 64'(rq.addr) + 64'(nbytes);
        r        = '0;
        if ((rq.addr & (nbytes - 1)) != 0 || end_addr > 64'(MEM_BYTES)) begin
            r.fault = 1'b1;
        end else if (rq.is_write == REQ_WRITE) begin
            for (i = 0; i < nbytes; i++) begin
                shadow_mem[rq.addr + i] = rq.wdata[8*i +: 8];
                byte_valid[rq.addr + i] = 1'b1;
            end
        end else begin
            for (i = 0; i < nbytes; i++) begin
                r.rdata[8*i +: 8] = shadow_mem[rq.addr + i];
            end
            // only two- and four-byte reads honor the sign flag
            if (rq.sext) begin
                if (rq.size == SIZE_B2 && r.rdata[15]) begin
                    r.rdata[63:16] = '1;
                end
                if (rq.size == SIZE_B4 && r.rdata[31]) begin
                    r.rdata[63:32] = '1;
                end
            end
        end
        return r;
    endfunction

    function automatic bit span_written(input logic [31:0] addr, input int unsigned nbytes);
        int i;
        for (i = 0; i < nbytes; i++) begin
            if (!byte_valid[addr + i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic req_t make_req(input logic w, input logic [1:0] sz, input logic sx,
                                      input logic [31:0] a, input logic [63:0] d);
        req_t rq;
        rq.is_write = w;
        rq.size     = sz;
        rq.sext     = sx;
        rq.addr     = a;
        rq.wdata    = d;
        return rq;
    endfunction

    // random access: mostly legal ones, near both ends or anywhere, some misaligned or out of range
    function automatic req_t random_request();
        req_t        rq;
        int unsigned nbytes;
        int unsigned kind;
        rq.is_write = 1'($urandom_range(0, 1));
        rq.size     = 2'($urandom_range(0, 3));
        rq.sext     = 1'($urandom_range(0, 1));
        rq.wdata    = {$urandom, $urandom};
        nbytes      = 1 << rq.size;
        kind        = $urandom_range(0, 99);
        if (kind < 85) begin
            case ($urandom_range(0, 2))
                0:       rq.addr = $urandom_range(0, 511);
                1:       rq.addr = $urandom_range(MEM_BYTES - 512, MEM_BYTES - 1);
                default: rq.addr = $urandom_range(0, MEM_BYTES - 1);
            endcase
            rq.addr = rq.addr & ~(nbytes - 1);
        end else if (kind < 92) begin
            // a single byte cannot be misaligned, so widen it
            if (rq.size == SIZE_B1) begin
                rq.size = SIZE_B8;
                nbytes  = 8;
            end
            rq.addr = $urandom_range(0, MEM_BYTES - 1);
            if ((rq.addr & (nbytes - 1)) == 0) begin
                rq.addr = rq.addr | 32'd1;
            end
        end else if (kind < 96) begin
            rq.addr = $urandom;
        end else begin
            rq.addr = MEM_BYTES - nbytes + $urandom_range(1, 8);
        end
        // never read bytes that were never written
        if (rq.is_write == REQ_READ && (rq.addr & (nbytes - 1)) == 0 &&
            64'(rq.addr) + 64'(nbytes) <= 64'(MEM_BYTES) &&
            !span_written(rq.addr, nbytes)) begin
            rq.is_write = REQ_WRITE;
        end
        return rq;
    endfunction

    // send one request item and record its expected response once accepted
    task automatic issue_request(input req_t rq);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rq.wdata, rq.addr, rq.sext, rq.size};
        s_tuser  <= rq.is_write;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_resp.push_back(predict_access(rq));
        @(negedge aclk);
    endtask

    // response side: random stall before each item
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    // compare each returned item with the oldest expectation
    always @(posedge aclk) begin : check_resp
        resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp.size() == 0) begin
                note_error($sformatf("unexpected response data=%h fault=%b", m_tdata, m_tuser));
            end else begin
                want = pending_resp.pop_front();
                if (m_tdata !== want.rdata) begin
                    note_error($sformatf("read_data expected %h got %h", want.rdata, m_tdata));
                end
                if (m_tuser[0] !== want.fault) begin
                    note_error($sformatf("fault expected %b got %b", want.fault, m_tuser[0]));
                end
            end
        end
    end

    // full-word writes at both ends and partial writes at the low end, read back
    task automatic test_basic_access();
        issue_request(make_req(REQ_WRITE, SIZE_B8, 1'b0, 32'd0, 64'hF0E1_D2C3_B4A5_9687));
        issue_request(make_req(REQ_WRITE, SIZE_B8, 1'b0, 32'd8, 64'h0000_0000_7FFF_7FFF));
        issue_request(make_req(REQ_WRITE, SIZE_B8, 1'b0, MEM_BYTES - 8, '1));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b0, 32'd0, '1));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b0, MEM_BYTES - 8, '0));
        issue_request(make_req(REQ_WRITE, SIZE_B1, 1'b1, 32'd1, 64'hFFFF_FFFF_FFFF_FF5A));
        issue_request(make_req(REQ_WRITE, SIZE_B2, 1'b0, 32'd2, 64'h1234_5678_9ABC_A55A));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b1, 32'd0, '0));
        issue_request(make_req(REQ_READ, SIZE_B1, 1'b0, MEM_BYTES - 1, '0));
    endtask

    // sign and zero extension for one, two and four byte reads
    task automatic test_sign_extension();
        issue_request(make_req(REQ_READ, SIZE_B1, 1'b1, 32'd7, '0));
        issue_request(make_req(REQ_READ, SIZE_B2, 1'b1, 32'd6, '0));
        issue_request(make_req(REQ_READ, SIZE_B2, 1'b0, 32'd6, '0));
        issue_request(make_req(REQ_READ, SIZE_B4, 1'b1, 32'd4, '0));
        issue_request(make_req(REQ_READ, SIZE_B4, 1'b0, 32'd4, '0));
        issue_request(make_req(REQ_READ, SIZE_B2, 1'b1, 32'd8, '0));
        issue_request(make_req(REQ_READ, SIZE_B4, 1'b1, 32'd8, '0));
    endtask

    // misaligned and out of range accesses leave memory untouched
    task automatic test_faults();
        issue_request(make_req(REQ_READ, SIZE_B2, 1'b0, 32'd1, '0));
        issue_request(make_req(REQ_WRITE, SIZE_B4, 1'b0, 32'd2, '1));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b0, 32'd4, '0));
        issue_request(make_req(REQ_READ, SIZE_B1, 1'b0, MEM_BYTES, '0));
        issue_request(make_req(REQ_WRITE, SIZE_B8, 1'b0, MEM_BYTES, '1));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b1, 32'hFFFF_FFF8, '0));
        issue_request(make_req(REQ_WRITE, SIZE_B1, 1'b0, 32'hFFFF_FFFF, '1));
        issue_request(make_req(REQ_READ, SIZE_B4, 1'b1, MEM_BYTES - 2, '0));
        issue_request(make_req(REQ_READ, SIZE_B8, 1'b0, 32'd0, '0));
    endtask

    // random traffic, with stretches where neither side idles
    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            issue_request(random_request());
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until every outstanding item has returned
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_resp.size() != 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_basic_access();
        test_sign_extension();
        test_faults();
        test_random_traffic(750);
        test_drain_pause();
        test_random_traffic(750);
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
